// ===== rtl/tpcs_pkg.sv =====
package tpcs_pkg;

   localparam int BYTE_W   = 8;
   localparam int PAY_W    = 7;
   localparam int COORD_W  = 14;
   localparam int COUNT_W  = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [COUNT_W-1:0] SAMPLE_LIMIT_RESET = 7'd60;
   localparam logic [COUNT_W-1:0] SAMPLE_CAP         = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX          = 7'd127;

   // Frame positions
   localparam logic [2:0] POS_IDLE = 3'd0;
   localparam logic [2:0] POS_HDR  = 3'd1;
   localparam logic [2:0] POS_LAST = 3'd4;

   // Header bits
   localparam int HDR_SYNC_BIT  = 7;
   localparam int HDR_BTN_BIT   = 6;
   localparam int HDR_ORDER_BIT = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_ENABLE   = 1'd1;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_RESP = 2'd1,
      KIND_PKT  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [BYTE_W-1:0]      resp;
      logic [COORD_W-1:0]     tx;
      logic [COORD_W-1:0]     ty;
      logic                   btn;
   } frame_evt_type;

   typedef struct packed {
      logic [COORD_W-1:0]     avg_x;
      logic [COORD_W-1:0]     avg_y;
      logic [COUNT_W-1:0]     count;
      logic                   done;
      logic                   pen_up;
   } samp_state_type;

   typedef struct packed {
      frame_evt_type          evt;
      samp_state_type         samp;
   } rsp_word_type;

endpackage

// ===== rtl/tpcs_if.sv =====
interface tpcs_req_if import tpcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface tpcs_rsp_if import tpcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [BYTE_W-1:0]   response_byte;
   logic [COORD_W-1:0]  touch_x;
   logic [COORD_W-1:0]  touch_y;
   logic                button_down;
   logic [COORD_W-1:0]  average_x;
   logic [COORD_W-1:0]  average_y;
   logic [COUNT_W-1:0]  samples_seen;
   logic                point_done;
   logic                pen_lifted;

   modport source (output valid, output kind, output response_byte, output touch_x,
                   output touch_y, output button_down, output average_x,
                   output average_y, output samples_seen, output point_done,
                   output pen_lifted, input ready);
   modport sink   (input valid, input kind, input response_byte, input touch_x,
                   input touch_y, input button_down, input average_x,
                   input average_y, input samples_seen, input point_done,
                   input pen_lifted, output ready);
endinterface

interface tpcs_csr_if import tpcs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tpcs_framer.sv =====
module tpcs_framer import tpcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                mode,
   input  logic [BYTE_W-1:0]   data_byte,
   output frame_evt_type       evt
);

   logic [2:0]          pos_ff, pos_in, pos_eff;
   logic [BYTE_W-1:0]   header_ff, header_in;
   logic [PAY_W-1:0]    pay_ff [3];
   logic [PAY_W-1:0]    pay_in [3];
   logic [PAY_W-1:0]    p4;

   always_comb begin
      pos_eff   = (pos_ff > POS_LAST) ? POS_IDLE : pos_ff;
      pos_in    = pos_ff;
      header_in = header_ff;
      pay_in    = pay_ff;
      p4        = data_byte[PAY_W-1:0];
      evt       = '0;
      if (!mode) begin
         priority if (data_byte[HDR_SYNC_BIT]) begin
            // sync bit restarts the frame anywhere
            header_in = data_byte;
            pos_in    = POS_HDR;
         end else if (pos_eff == POS_IDLE) begin
            pos_in = POS_IDLE;
            if (data_byte != '0) begin
               evt.kind = KIND_RESP;
               evt.resp = data_byte;
            end
         end else if (pos_eff < POS_LAST) begin
            pay_in[2'(pos_eff - 3'd1)] = data_byte[PAY_W-1:0];
            pos_in = pos_eff + 3'd1;
         end else begin
            pos_in   = POS_IDLE;
            evt.kind = KIND_PKT;
            evt.btn  = header_ff[HDR_BTN_BIT];
            if (header_ff[HDR_ORDER_BIT]) begin
               evt.tx = {pay_ff[1], pay_ff[0]};
               evt.ty = {p4, pay_ff[2]};
            end else begin
               evt.tx = {pay_ff[0], pay_ff[1]};
               evt.ty = {pay_ff[2], p4};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_IDLE;
         header_ff <= '0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         header_ff <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pay_ff <= pay_in;
      end
   end

endmodule

// ===== rtl/tpcs_sampler.sv =====
module tpcs_sampler import tpcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                start,
   input  logic                packet,
   input  logic [COORD_W-1:0]  tx,
   input  logic [COORD_W-1:0]  ty,
   input  logic                btn,
   input  logic [COUNT_W-1:0]  limit,
   output samp_state_type      nxt
);

   samp_state_type      st_ff, st_in;
   logic [COUNT_W-1:0]  win_lo;
   logic [COUNT_W+1:0]  lim3;
   logic [COUNT_W-1:0]  win_hi;
   logic                in_window;
   logic [COORD_W:0]    sum_x, sum_y;

   always_comb begin
      win_lo    = limit >> 2;
      lim3      = (COUNT_W+2)'(limit) + {1'b0, limit, 1'b0};
      win_hi    = lim3[COUNT_W+1:2];
      in_window = (st_ff.count > win_lo) && (st_ff.count <= win_hi);
      sum_x     = (COORD_W+1)'(st_ff.avg_x) + (COORD_W+1)'(tx);
      sum_y     = (COORD_W+1)'(st_ff.avg_y) + (COORD_W+1)'(ty);
      st_in     = st_ff;
      if (start) begin
         st_in.avg_x  = '0;
         st_in.avg_y  = '0;
         st_in.done   = 1'b0;
         st_in.pen_up = 1'b0;
      end else if (packet) begin
         priority if (st_ff.count <= limit && btn) begin
            if (in_window) begin
               st_in.avg_x = sum_x[COORD_W:1];
               st_in.avg_y = sum_y[COORD_W:1];
            end
            if (st_ff.count != COUNT_MAX) begin
               st_in.count = st_ff.count + 7'd1;
            end
         end else if (st_ff.count < limit && !btn) begin
            // error touch: restart the window
            st_in.count = '0;
            st_in.avg_x = '0;
            st_in.avg_y = '0;
         end else if (st_ff.count > limit) begin
            st_in.done  = 1'b1;
            st_in.count = (st_ff.count >= SAMPLE_CAP) ? SAMPLE_CAP : st_ff.count + 7'd1;
            if (!btn) begin
               st_in.count  = '0;
               st_in.pen_up = 1'b1;
            end
         end else begin
            st_in = st_ff;
         end
      end
      nxt = st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/touch_packet_calibration_sampler.sv =====
// An accepted request waits in the input register; its result is held in the result register, which
// drives the response port. Throughput: one request per cycle while the response side is not stalled;
// the input register and the result register move together.
// Reset (synchronous, active high): framing and sampler state clear, sample limit
// returns to 60, calibration off, both pipeline registers empty.
module touch_packet_calibration_sampler import tpcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   tpcs_req_if.sink       req_chan,
   tpcs_rsp_if.source     rsp_chan,
   tpcs_csr_if.sink       csr_chan
);

   // Configuration registers
   logic [COUNT_W-1:0]  limit_ff;
   logic                enable_ff;

   // Input register
   logic                in_valid_ff, in_valid_in;
   logic                in_mode_ff;
   logic [BYTE_W-1:0]   in_byte_ff;

   // Result register
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        rsp_ff;

   logic                advance;
   logic                fire;
   logic                req_take;
   frame_evt_type       evt;
   samp_state_type      samp_next;

   // Advance the pipeline whenever the result slot is free or being drained.
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign fire     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // Configuration writes land immediately; the port never stalls.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= SAMPLE_LIMIT_RESET;
         enable_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SAMPLE_LIMIT: limit_ff  <= csr_chan.data;
            CSR_CAL_ENABLE:   enable_ff <= csr_chan.data[0];
         endcase
      end
   end

   // Hold a request in the input register until the result slot can take it.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_chan.mode;
         in_byte_ff <= req_chan.data_byte;
      end
      if (fire) begin
         rsp_ff.evt  <= evt;
         rsp_ff.samp <= samp_next;
      end
   end

   tpcs_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .mode      (in_mode_ff),
      .data_byte (in_byte_ff),
      .evt       (evt)
   );

   // The sampler updates on a finished packet with calibration on; a start request clears its averages and flags.
   tpcs_sampler u_sampler (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .start  (in_mode_ff),
      .packet ((evt.kind == KIND_PKT) && enable_ff),
      .tx     (evt.tx),
      .ty     (evt.ty),
      .btn    (evt.btn),
      .limit  (limit_ff),
      .nxt    (samp_next)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = rsp_ff.evt.kind;
   assign rsp_chan.response_byte = rsp_ff.evt.resp;
   assign rsp_chan.touch_x       = rsp_ff.evt.tx;
   assign rsp_chan.touch_y       = rsp_ff.evt.ty;
   assign rsp_chan.button_down   = rsp_ff.evt.btn;
   assign rsp_chan.average_x     = rsp_ff.samp.avg_x;
   assign rsp_chan.average_y     = rsp_ff.samp.avg_y;
   assign rsp_chan.samples_seen  = rsp_ff.samp.count;
   assign rsp_chan.point_done    = rsp_ff.samp.done;
   assign rsp_chan.pen_lifted    = rsp_ff.samp.pen_up;

`ifndef SYNTHESIS
   // A pending request in the input register is never dropped while stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input request lost during stall");

   // Pen-up is only reached from the done state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.pen_lifted |-> rsp_chan.point_done)
      else $error("pen lifted without point done");

   // A response byte is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_RESP |-> rsp_chan.response_byte != '0)
      else $error("zero response byte emitted");

   // Coordinates only accompany a completed packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind != KIND_PKT |->
         rsp_chan.touch_x == '0 && rsp_chan.touch_y == '0 && !rsp_chan.button_down)
      else $error("position fields set outside a packet");

   // The sample count saturates at its cap once a point is done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.point_done && !rsp_chan.pen_lifted &&
      rsp_chan.samples_seen > limit_ff |-> rsp_chan.samples_seen <= SAMPLE_CAP)
      else $error("sample count above cap");
`endif

endmodule

// ===== dv/touch_packet_calibration_sampler_tb.sv =====
`timescale 1ns / 1ps

module touch_packet_calibration_sampler_tb;
   import tpcs_pkg::*;

   // Idle cycles required with nothing outstanding before a drain point is
   // considered complete; covers the input and result registers with margin.
   localparam int SETTLE_CYCLES = 6;
   // Stop adding random calibration points after this many requests.
   localparam int TARGET_ITEMS  = 1850;

   typedef enum logic [1:0] {
      STIM_REQ,
      STIM_CSR,
      STIM_DRAIN
   } stim_op_type;

   typedef struct {
      stim_op_type            op;
      logic                   mode;
      logic [BYTE_W-1:0]      data;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  wdata;
      int                     gap;
   } stim_type;

   logic clock = 1'b0;
   logic reset;

   tpcs_req_if req_bus ();
   tpcs_rsp_if rsp_bus ();
   tpcs_csr_if csr_bus ();

   touch_packet_calibration_sampler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #10 clock = ~clock;

   // Stimulus and expectation stores
   stim_type      pending[$];
   rsp_word_type  expected_rsp[$];
   int            stim_items;
   bit            stim_burst;
   int            fail_count;
   logic          pipe_empty;
   logic          stim_done;

   // Shadow of the block: configuration, framer and calibration sampler
   logic [COUNT_W-1:0]  cfg_limit;
   logic                cfg_cal;
   logic [2:0]          fr_pos;
   logic [BYTE_W-1:0]   fr_hdr;
   logic [PAY_W-1:0]    fr_pay[4];
   logic [COUNT_W-1:0]  smp_count;
   logic [COORD_W-1:0]  smp_avg_x;
   logic [COORD_W-1:0]  smp_avg_y;
   logic                smp_done;
   logic                smp_pen_up;

   // Driver and monitor bookkeeping
   int   drv_hold;
   bit   drv_armed;
   int   drv_settle;
   logic req_go;
   logic csr_go;
   int   mon_stall;
   int   mon_calm;

   // Mostly back-to-back, some short waits, a few long ones.
   function automatic int pick_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      else if (r == 1) return '1;
      else return COORD_W'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders: fill the pending queue before reset is released.
   // ---------------------------------------------------------------------
   task automatic add_req(input logic mode, input logic [BYTE_W-1:0] data);
      stim_type s;
      s.op    = STIM_REQ;
      s.mode  = mode;
      s.data  = data;
      s.idx   = '0;
      s.wdata = '0;
      s.gap   = stim_burst ? 0 : pick_wait();
      pending.push_back(s);
      stim_items++;
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] wdata);
      stim_type s;
      s.op    = STIM_CSR;
      s.mode  = 1'b0;
      s.data  = '0;
      s.idx   = idx;
      s.wdata = wdata;
      s.gap   = 0;
      pending.push_back(s);
   endtask

   task automatic add_drain();
      stim_type s;
      s.op    = STIM_DRAIN;
      s.mode  = 1'b0;
      s.data  = '0;
      s.idx   = '0;
      s.wdata = '0;
      s.gap   = 0;
      pending.push_back(s);
   endtask

   // Full 5-byte position packet; header filler bits are random.
   task automatic add_packet(input logic down, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
      logic [BYTE_W-1:0] hdr;
      hdr = BYTE_W'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      hdr[HDR_BTN_BIT]  = down;
      add_req(1'b0, hdr);
      if (hdr[HDR_ORDER_BIT]) begin
         add_req(1'b0, {1'b0, x[6:0]});
         add_req(1'b0, {1'b0, x[13:7]});
         add_req(1'b0, {1'b0, y[6:0]});
         add_req(1'b0, {1'b0, y[13:7]});
      end else begin
         add_req(1'b0, {1'b0, x[13:7]});
         add_req(1'b0, {1'b0, x[6:0]});
         add_req(1'b0, {1'b0, y[13:7]});
         add_req(1'b0, {1'b0, y[6:0]});
      end
   endtask

   // Stray traffic: response bytes (zero included), start-point requests,
   // and frames cut short by the next header.
   task automatic add_noise();
      int n;
      case ($urandom_range(0, 2))
         0: add_req(1'b0, {1'b0, 7'($urandom)});
         1: add_req(1'b1, BYTE_W'($urandom));
         default: begin
            add_req(1'b0, 8'h80 | BYTE_W'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) add_req(1'b0, {1'b0, 7'($urandom)});
         end
      endcase
   endtask

   // One calibration point: optional start, a run of pen-down packets with
   // occasional error touches, then pen-up packets.
   task automatic add_point(input int n_down, input int n_up, input int err_pct);
      if ($urandom_range(0, 3) != 0) add_req(1'b1, BYTE_W'($urandom));
      repeat (n_down) begin
         if ($urandom_range(0, 14) == 0) add_noise();
         add_packet($urandom_range(0, 99) >= err_pct, pick_coord(), pick_coord());
      end
      repeat (n_up) add_packet(1'b0, pick_coord(), pick_coord());
   endtask

   // Wait for the block to go quiet, then reprogram both registers.
   task automatic add_phase(input logic [CSR_DATA_W-1:0] limit, input logic cal);
      add_drain();
      add_csr(CSR_SAMPLE_LIMIT, limit);
      add_csr(CSR_CAL_ENABLE, {6'($urandom), cal});
      stim_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic build_stimulus();
      stim_burst = 1'b0;
      // Reset values of the registers: calibration off, limit 60.
      add_req(1'b0, 8'h01);                     // smallest response byte
      add_req(1'b0, 8'h7F);                     // largest response byte
      add_req(1'b0, 8'h00);                     // zero byte outside a frame, dropped
      add_req(1'b1, 8'hFF);                     // start point, data ignored
      add_req(1'b0, 8'hFF);                     // all header bits, low-first order
      repeat (4) add_req(1'b0, 8'h7F);
      add_req(1'b0, 8'h80);                     // bare header, high-first order
      repeat (4) add_req(1'b0, 8'h00);
      add_req(1'b0, 8'hC0);
      add_req(1'b0, 8'h01);
      add_req(1'b0, 8'h02);
      add_req(1'b0, 8'h03);
      add_req(1'b0, 8'h04);
      add_req(1'b0, 8'h90);                     // header of a frame that is cut short by the next header
      add_req(1'b0, 8'h11);
      add_req(1'b0, 8'hD5);
      add_req(1'b0, 8'h55);
      add_req(1'b0, 8'h2A);
      add_req(1'b0, 8'h00);
      add_req(1'b0, 8'h7F);
      add_req(1'b0, 8'h40);

      // Limit of 4: count runs into the cap of 100, then pen up.
      add_phase(7'd4, 1'b1);
      add_point(110, 3, 0);
      // Limit of zero: no averaging window at all.
      add_phase(7'd0, 1'b1);
      add_point(6, 2, 10);
      add_point(6, 2, 10);
      // Largest limit: count saturates at 127 in the pen-down branch.
      add_phase(7'd127, 1'b1);
      add_point(130, 2, 0);
      // Limit of 98, partial run with error touches.
      add_phase(7'd98, 1'b1);
      add_point(30, 2, 5);
      // Calibration off: packets still decode, and only start requests touch the sampler state.
      add_phase(7'd10, 1'b0);
      add_point(8, 2, 10);

      while (stim_items < TARGET_ITEMS) begin
         logic [CSR_DATA_W-1:0] lim;
         if ($urandom_range(0, 5) == 0) lim = CSR_DATA_W'($urandom_range(1, 3));
         else lim = CSR_DATA_W'($urandom_range(4, 20));
         add_phase(lim, $urandom_range(0, 7) != 0);
         repeat ($urandom_range(1, 3))
            add_point(int'(lim) + $urandom_range(0, 8), $urandom_range(1, 3), 6);
      end
      add_drain();
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   task automatic run_window(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                             input logic down);
      int lim;
      int c;
      lim = int'(cfg_limit);
      c   = int'(smp_count);
      if (c <= lim && down) begin
         // average only inside the middle half of the sample window
         if (c > lim / 4 && c <= (lim * 3) / 4) begin
            smp_avg_x = COORD_W'((int'(smp_avg_x) + int'(tx)) >> 1);
            smp_avg_y = COORD_W'((int'(smp_avg_y) + int'(ty)) >> 1);
         end
         if (c < int'(COUNT_MAX)) c++;
      end else if (c < lim && !down) begin
         // error touch: start the point over
         c = 0;
         smp_avg_x = '0;
         smp_avg_y = '0;
      end else if (c > lim) begin
         smp_done = 1'b1;
         c++;
         if (c > int'(SAMPLE_CAP)) c = int'(SAMPLE_CAP);
         if (!down) begin
            c = 0;
            smp_pen_up = 1'b1;
         end
      end
      smp_count = COUNT_W'(c);
   endtask

   task automatic predict_step(input logic mode, input logic [BYTE_W-1:0] b,
                               output rsp_word_type r);
      int p;
      logic [COORD_W-1:0] tx;
      logic [COORD_W-1:0] ty;
      r = '0;
      r.evt.kind = KIND_NONE;
      if (mode) begin
         smp_avg_x  = '0;
         smp_avg_y  = '0;
         smp_done   = 1'b0;
         smp_pen_up = 1'b0;
      end else begin
         p = int'(fr_pos);
         if (p > int'(POS_LAST)) p = int'(POS_IDLE);
         if (p == int'(POS_IDLE)) begin
            if (b[HDR_SYNC_BIT]) begin
               fr_hdr = b;
               fr_pos = POS_HDR;
            end else begin
               fr_pos = POS_IDLE;
               if (b != '0) begin
                  r.evt.kind = KIND_RESP;
                  r.evt.resp = b;
               end
            end
         end else if (b[HDR_SYNC_BIT]) begin
            fr_hdr = b;
            fr_pos = POS_HDR;
         end else begin
            fr_pay[2'(p - 1)] = b[PAY_W-1:0];
            if (p < int'(POS_LAST)) begin
               fr_pos = 3'(p + 1);
            end else begin
               fr_pos = POS_IDLE;
               if (fr_hdr[HDR_ORDER_BIT]) begin
                  tx = {fr_pay[1], fr_pay[0]};
                  ty = {fr_pay[3], fr_pay[2]};
               end else begin
                  tx = {fr_pay[0], fr_pay[1]};
                  ty = {fr_pay[2], fr_pay[3]};
               end
               r.evt.kind = KIND_PKT;
               r.evt.tx   = tx;
               r.evt.ty   = ty;
               r.evt.btn  = fr_hdr[HDR_BTN_BIT];
               if (cfg_cal) run_window(tx, ty, fr_hdr[HDR_BTN_BIT]);
            end
         end
      end
      r.samp.avg_x  = smp_avg_x;
      r.samp.avg_y  = smp_avg_y;
      r.samp.count  = smp_count;
      r.samp.done   = smp_done;
      r.samp.pen_up = smp_pen_up;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: pop the pending queue; hold valid until the handshake lands.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         drv_armed  = 1'b0;
         drv_hold   = 0;
         drv_settle = 0;
      end else begin
         // keep a request that has not been taken yet
         req_go = req_bus.valid && !req_bus.ready;
         csr_go = csr_bus.valid && !csr_bus.ready;
         if (!req_go && !csr_go && pending.size() != 0) begin
            case (pending[0].op)
               STIM_REQ: begin
                  if (!drv_armed) begin
                     drv_hold  = pending[0].gap;
                     drv_armed = 1'b1;
                  end
                  if (drv_hold > 0) begin
                     drv_hold--;
                  end else begin
                     req_go = 1'b1;
                     req_bus.mode      <= pending[0].mode;
                     req_bus.data_byte <= pending[0].data;
                     drv_armed = 1'b0;
                     void'(pending.pop_front());
                  end
               end
               STIM_CSR: begin
                  csr_go = 1'b1;
                  csr_bus.index <= pending[0].idx;
                  csr_bus.data  <= pending[0].wdata;
                  void'(pending.pop_front());
               end
               default: begin
                  // drain: count idle checks with nothing outstanding; any outstanding response restarts the count
                  if (!pipe_empty) begin
                     drv_settle = 0;
                  end else if (drv_settle < SETTLE_CYCLES) begin
                     drv_settle++;
                  end else begin
                     drv_settle = 0;
                     void'(pending.pop_front());
                     if (pending.size() == 0) stim_done <= 1'b1;
                  end
               end
            endcase
         end
         req_bus.valid <= req_go;
         csr_bus.valid <= csr_go;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: track register writes, predict every accepted request, check
   // every accepted response against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type fresh;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         pipe_empty    <= 1'b1;
         mon_stall  = 0;
         mon_calm   = 0;
         cfg_limit  = SAMPLE_LIMIT_RESET;
         cfg_cal    = 1'b0;
         fr_pos     = POS_IDLE;
         fr_hdr     = '0;
         smp_count  = '0;
         smp_avg_x  = '0;
         smp_avg_y  = '0;
         smp_done   = 1'b0;
         smp_pen_up = 1'b0;
         foreach (fr_pay[i]) fr_pay[i] = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_SAMPLE_LIMIT: cfg_limit = csr_bus.data;
               CSR_CAL_ENABLE:   cfg_cal   = csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_step(req_bus.mode, req_bus.data_byte, fresh);
            expected_rsp.push_back(fresh);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response, kind %0d", $time, rsp_bus.kind);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("kind",          32'(want.evt.kind),    32'(rsp_bus.kind));
               check_field("response_byte", 32'(want.evt.resp),    32'(rsp_bus.response_byte));
               check_field("touch_x",       32'(want.evt.tx),      32'(rsp_bus.touch_x));
               check_field("touch_y",       32'(want.evt.ty),      32'(rsp_bus.touch_y));
               check_field("button_down",   32'(want.evt.btn),     32'(rsp_bus.button_down));
               check_field("average_x",     32'(want.samp.avg_x),  32'(rsp_bus.average_x));
               check_field("average_y",     32'(want.samp.avg_y),  32'(rsp_bus.average_y));
               check_field("samples_seen",  32'(want.samp.count),  32'(rsp_bus.samples_seen));
               check_field("point_done",    32'(want.samp.done),   32'(rsp_bus.point_done));
               check_field("pen_lifted",    32'(want.samp.pen_up), 32'(rsp_bus.pen_lifted));
            end
         end
         pipe_empty <= (expected_rsp.size() == 0);

         // Backpressure: random stalls, with occasional long calm stretches.
         if (mon_calm > 0) begin
            mon_calm--;
            rsp_bus.ready <= 1'b1;
         end else if (mon_stall > 0) begin
            mon_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0) mon_calm = $urandom_range(100, 300);
            else mon_stall = pick_wait();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      stim_done         = 1'b0;
      fail_count        = 0;
      stim_items        = 0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = 1'b0;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
      end
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: ends the test as failed long after the slowest legal run.
   initial begin
      #20_000_000;
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
